/* rtl/lodi_pkg.sv */
`default_nettype none
package lodi_pkg;

  typedef logic [1:0] alu_op_t;

  localparam alu_op_t OP_MUL  = 2'd0;
  localparam alu_op_t OP_SQRT = 2'd1;
  localparam alu_op_t OP_DIV  = 2'd2;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } alu_stat_t;

  typedef logic [1:0] cfg_addr_t;

  localparam cfg_addr_t REG_TIME_STEP  = 2'd0;
  localparam cfg_addr_t REG_STEP_COUNT = 2'd1;
  localparam cfg_addr_t REG_SCHEME     = 2'd2;

endpackage
`default_nettype wire

/* rtl/lodi_alu.sv */
`default_nettype none
module lodi_alu #(
  parameter int FRAC_BITS = 30
) (
  input  wire                          clk,
  input  wire                          rst,
  input  lodi_pkg::alu_req_t           req,
  input  wire  [2*FRAC_BITS+3:0]       opa,
  input  wire  [FRAC_BITS+2:0]         opb,
  output lodi_pkg::alu_stat_t          stat,
  output logic [2*FRAC_BITS+3:0]       acc_out,
  output logic [FRAC_BITS+1:0]         res_out
);
  import lodi_pkg::*;

  localparam int W    = FRAC_BITS + 1;
  localparam int NR   = FRAC_BITS + 2;
  localparam int XW   = 2 * NR;
  localparam int CNTW = $clog2(NR + 1);

  logic            busy;
  logic            done;
  logic [CNTW-1:0] cnt;
  alu_op_t         op;
  logic [XW-1:0]   acc;
  logic [XW-1:0]   sh;
  logic [NR:0]     b;
  logic [NR-1:0]   res;
  logic            ovf;

  logic [XW-1:0]   add_x;
  logic [XW-1:0]   add_y;
  logic            add_sub;
  logic [XW:0]     add_sum;
  logic            keep;

  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    unique case (op)
      OP_MUL: begin
        add_x = {acc[XW-2:0], 1'b0};
        add_y = sh[XW-1] ? XW'(b) : '0;
      end
      OP_SQRT: begin
        add_x   = {acc[XW-3:0], sh[XW-1:XW-2]};
        add_y   = XW'({res, 2'b01});
        add_sub = 1'b1;
      end
      OP_DIV: begin
        add_x   = {acc[XW-2:0], sh[XW-1]};
        add_y   = XW'(b);
        add_sub = 1'b1;
      end
      default: begin
        add_x = '0;
      end
    endcase
    add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + (XW+1)'(add_sub);
    keep    = add_sum[XW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= (req.op == OP_MUL) ? CNTW'(W) : CNTW'(NR);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op  <= req.op;
      b   <= opb;
      res <= '0;
      ovf <= 1'b0;
      unique case (req.op)
        OP_MUL: begin
          acc <= '0;
          sh  <= opa << (XW - W);
        end
        OP_SQRT: begin
          acc <= '0;
          sh  <= opa;
        end
        OP_DIV: begin
          acc <= XW'(opa[XW-1:NR]);
          sh  <= opa << NR;
          ovf <= ({1'b0, opa[XW-1:NR]} >= opb);
        end
        default: begin
          acc <= '0;
          sh  <= '0;
        end
      endcase
    end else if (busy) begin
      sh <= (op == OP_SQRT) ? (sh << 2) : (sh << 1);
      if (op == OP_MUL) begin
        acc <= add_sum[XW-1:0];
      end else begin
        acc <= keep ? add_sum[XW-1:0] : add_x;
        res <= {res[NR-2:0], keep};
      end
    end
  end

  assign stat.done = done;
  assign stat.ovf  = ovf;
  assign acc_out   = acc;
  assign res_out   = res;

endmodule
`default_nettype wire

/* rtl/logistic_ode_integrator.sv */
`default_nettype none
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tdata: initial_value, Q1.FRAC_BITS
// m_*      out  m_tvalid/m_tready  m_tdata: final_value, Q1.FRAC_BITS
// cfg_*    in   cfg_wen            cfg_addr, cfg_wdata (time_step, step_count, scheme_select)
//
// An explicit step runs two products on the unit; an implicit step runs two products,
// a square root and a quotient, and an implicit step from zero skips the unit.
// The shared shift/add unit retires one product, root or quotient bit per cycle.
// s_tready is high only while idle; the output register lets a new request in while
// the last result waits. Reset is synchronous and clears control and config state only.
module logistic_ode_integrator #(
  parameter int FRAC_BITS = 30,
  parameter int STEP_BITS = 20
) (
  input  wire                                              clk,
  input  wire                                              rst,
  input  wire                                              s_tvalid,
  output logic                                             s_tready,
  input  wire  [((FRAC_BITS+8)/8)*8-1:0]                   s_tdata,  // initial_value
  output logic                                             m_tvalid,
  input  wire                                              m_tready,
  output logic [((FRAC_BITS+8)/8)*8-1:0]                   m_tdata,  // final_value
  input  wire                                              cfg_wen,
  input  lodi_pkg::cfg_addr_t                              cfg_addr,
  input  wire  [(FRAC_BITS+1 > STEP_BITS ? FRAC_BITS+1 : STEP_BITS)-1:0] cfg_wdata
);
  import lodi_pkg::*;

  localparam int W  = FRAC_BITS + 1;
  localparam int NR = FRAC_BITS + 2;
  localparam int XW = 2 * NR;
  localparam int TW = ((FRAC_BITS + 8) / 8) * 8;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CHECK = 4'd1;
  localparam logic [3:0] ST_E1_GO = 4'd2;
  localparam logic [3:0] ST_E1_WT = 4'd3;
  localparam logic [3:0] ST_E2_GO = 4'd4;
  localparam logic [3:0] ST_E2_WT = 4'd5;
  localparam logic [3:0] ST_I1_GO = 4'd6;
  localparam logic [3:0] ST_I1_WT = 4'd7;
  localparam logic [3:0] ST_I2_GO = 4'd8;
  localparam logic [3:0] ST_I2_WT = 4'd9;
  localparam logic [3:0] ST_I3_GO = 4'd10;
  localparam logic [3:0] ST_I3_WT = 4'd11;
  localparam logic [3:0] ST_I4_GO = 4'd12;
  localparam logic [3:0] ST_I4_WT = 4'd13;
  localparam logic [3:0] ST_FIN   = 4'd14;

  logic [3:0]           state;
  logic [3:0]           state_next;

  logic [W-1:0]         time_step;
  logic [STEP_BITS-1:0] step_count;
  logic                 scheme_select;

  logic [W-1:0]         r;
  logic [W-1:0]         dt;
  logic [STEP_BITS-1:0] steps;
  logic                 scheme;
  logic [W-1:0]         t;
  logic [XW-1:0]        disc;
  logic [NR:0]          den;
  logic [W-1:0]         out_data;
  logic                 out_valid;

  alu_req_t             alu_req;
  alu_stat_t            alu_stat;
  logic [XW-1:0]        alu_opa;
  logic [NR:0]          alu_opb;
  logic [XW-1:0]        alu_acc;
  logic [NR-1:0]        alu_res;

  logic                 accept;
  logic                 load;
  logic [W-1:0]         in_val;
  logic [W-1:0]         a_val;
  logic [W:0]           exp_sum;
  logic [NR:0]          den_n;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign load     = (state == ST_FIN) && (!out_valid || m_tready);
  assign m_tvalid = out_valid;
  assign m_tdata  = TW'(out_data);

  assign in_val  = s_tdata[W-1:0];
  assign a_val   = ONE - dt;
  assign exp_sum = {1'b0, r} + {1'b0, alu_acc[FRAC_BITS +: W]};
  assign den_n   = (NR+1)'(a_val) + (NR+1)'(alu_res);

  lodi_alu #(
    .FRAC_BITS(FRAC_BITS)
  ) u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .opa    (alu_opa),
    .opb    (alu_opb),
    .stat   (alu_stat),
    .acc_out(alu_acc),
    .res_out(alu_res)
  );

  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op    = OP_MUL;
    alu_opa       = '0;
    alu_opb       = '0;
    unique case (state)
      ST_E1_GO: begin
        alu_req.start = 1'b1;
        alu_opa       = XW'(r);
        alu_opb       = (NR+1)'(ONE - r);
      end
      ST_E2_GO: begin
        alu_req.start = 1'b1;
        alu_opa       = XW'(t);
        alu_opb       = (NR+1)'(dt);
      end
      ST_I1_GO: begin
        alu_req.start = 1'b1;
        alu_opa       = XW'(a_val);
        alu_opb       = (NR+1)'(a_val);
      end
      ST_I2_GO: begin
        alu_req.start = 1'b1;
        alu_opa       = XW'(dt);
        alu_opb       = (NR+1)'(r);
      end
      ST_I3_GO: begin
        alu_req.start = 1'b1;
        alu_req.op    = OP_SQRT;
        alu_opa       = disc;
      end
      ST_I4_GO: begin
        alu_req.start = 1'b1;
        alu_req.op    = OP_DIV;
        alu_opa       = XW'(r) << (FRAC_BITS + 1);
        alu_opb       = den;
      end
      default: begin
        alu_req.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_CHECK;
      ST_CHECK: begin
        if (steps == '0) begin
          state_next = ST_FIN;
        end else if (scheme) begin
          state_next = (r == '0) ? ST_CHECK : ST_I1_GO;
        end else begin
          state_next = ST_E1_GO;
        end
      end
      ST_E1_GO: state_next = ST_E1_WT;
      ST_E1_WT: if (alu_stat.done) state_next = ST_E2_GO;
      ST_E2_GO: state_next = ST_E2_WT;
      ST_E2_WT: if (alu_stat.done) state_next = ST_CHECK;
      ST_I1_GO: state_next = ST_I1_WT;
      ST_I1_WT: if (alu_stat.done) state_next = ST_I2_GO;
      ST_I2_GO: state_next = ST_I2_WT;
      ST_I2_WT: if (alu_stat.done) state_next = ST_I3_GO;
      ST_I3_GO: state_next = ST_I3_WT;
      ST_I3_WT: begin
        if (alu_stat.done) state_next = (den_n == '0) ? ST_CHECK : ST_I4_GO;
      end
      ST_I4_GO: state_next = ST_I4_WT;
      ST_I4_WT: if (alu_stat.done) state_next = ST_CHECK;
      ST_FIN:   if (load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      time_step     <= ONE;
      step_count    <= STEP_BITS'(1);
      scheme_select <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wen) begin
        unique case (cfg_addr)
          REG_TIME_STEP:  time_step     <= cfg_wdata[W-1:0];
          REG_STEP_COUNT: step_count    <= cfg_wdata[STEP_BITS-1:0];
          REG_SCHEME:     scheme_select <= cfg_wdata[0];
          default:        ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data <= r;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          r      <= (in_val > ONE) ? ONE : in_val;
          dt     <= (time_step > ONE) ? ONE : time_step;
          steps  <= step_count;
          scheme <= scheme_select;
        end
      end
      ST_CHECK: begin
        if (steps != '0 && scheme && r == '0) steps <= steps - 1'b1;
      end
      ST_E1_WT: begin
        if (alu_stat.done) t <= alu_acc[FRAC_BITS +: W];
      end
      ST_E2_WT: begin
        if (alu_stat.done) begin
          r     <= (exp_sum > (W+1)'(ONE)) ? ONE : exp_sum[W-1:0];
          steps <= steps - 1'b1;
        end
      end
      ST_I1_WT: begin
        if (alu_stat.done) disc <= alu_acc;
      end
      ST_I2_WT: begin
        if (alu_stat.done) disc <= disc + (alu_acc << 2);
      end
      ST_I3_WT: begin
        if (alu_stat.done) begin
          den <= den_n;
          if (den_n == '0) begin
            r     <= '0;
            steps <= steps - 1'b1;
          end
        end
      end
      ST_I4_WT: begin
        if (alu_stat.done) begin
          r     <= (alu_stat.ovf || alu_res > NR'(ONE)) ? ONE : alu_res[W-1:0];
          steps <= steps - 1'b1;
        end
      end
      default: begin
        t <= t;
      end
    endcase
  end

endmodule
`default_nettype wire

/* dv/testbench.sv */
module testbench;
  import lodi_pkg::*;

  localparam bit [63:0] UNITY   = 64'h4000_0000;
  localparam bit [30:0] UNITY31 = 31'h4000_0000;

  class integrator_scoreboard;
    bit [63:0] time_step;
    bit [63:0] step_count;
    bit        implicit_mode;
    bit [30:0] expected_finals[$];
    int        errors;
    int        requests;
    int        finals_checked;

    function new();
      time_step     = UNITY;
      step_count    = 1;
      implicit_mode = 1'b0;
    endfunction

    function void write_reg(cfg_addr_t addr, bit [30:0] value);
      case (addr)
        REG_TIME_STEP:  time_step = value;
        REG_STEP_COUNT: step_count = value[19:0];
        REG_SCHEME:     implicit_mode = value[0];
        default: ;
      endcase
    endfunction

    function bit [63:0] explicit_step(bit [63:0] r, bit [63:0] dt);
      bit [127:0] prod;
      bit [63:0]  growth;
      bit [63:0]  next;
      prod   = r * (UNITY - r);
      growth = prod >> 30;
      prod   = dt * growth;
      next   = r + prod[93:30];
      return next > UNITY ? UNITY : next;
    endfunction

    function bit [63:0] implicit_step(bit [63:0] z, bit [63:0] dt);
      bit [127:0] a;
      bit [127:0] disc;
      bit [127:0] sq;
      bit [127:0] num;
      bit [127:0] quo;
      bit [63:0]  root;
      bit [63:0]  cand;
      bit [63:0]  den;
      if (z == 0) return 0;
      a    = UNITY - dt;
      disc = a * a + ((dt * z) << 2);
      root = 0;
      for (int b = 62; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        sq   = cand;
        if (sq * sq <= disc) root = cand;
      end
      den = a[63:0] + root;
      if (den == 0) return 0;
      num = z;
      num = num << 31;
      quo = num / den;
      return quo > UNITY ? UNITY : quo[63:0];
    endfunction

    function void note_start(bit [31:0] data);
      bit [63:0] dt;
      bit [63:0] r;
      bit [63:0] left;
      dt = time_step > UNITY ? UNITY : time_step;
      r  = data[30:0];
      if (r > UNITY) r = UNITY;
      for (left = step_count; left != 0; left--)
        r = implicit_mode ? implicit_step(r, dt) : explicit_step(r, dt);
      expected_finals.push_back(r[30:0]);
      requests++;
    endfunction

    task report(string what, bit [30:0] got, bit [30:0] want);
      errors++;
      $display("mismatch %0d: %s got %h want %h", errors, what, got, want);
    endtask

    task check_final(bit [31:0] data);
      bit [30:0] want;
      if (expected_finals.size() == 0) begin
        report("unexpected final_value", data[30:0], '0);
      end else begin
        want = expected_finals.pop_front();
        finals_checked++;
        if (data[30:0] !== want) report("final_value", data[30:0], want);
      end
    endtask

    function int pending();
      return expected_finals.size();
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;  // [30:0] initial_value
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;       // [30:0] final_value
  logic        cfg_wen = 1'b0;
  cfg_addr_t   cfg_addr = REG_TIME_STEP;
  logic [30:0] cfg_wdata = '0;

  integrator_scoreboard board;
  int tx_idle_pct = 19;
  int rx_stall_pct = 75;

  logistic_ode_integrator uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_wen(cfg_wen),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_final(m_tdata);
    m_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  task automatic send(bit [30:0] start);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, start};
    do @(posedge clk); while (!s_tready);
    board.note_start({1'b0, start});
  endtask

  // drop valid and hold until every final value is back
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_cfg(cfg_addr_t addr, bit [30:0] value);
    cfg_wen   <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    board.write_reg(addr, value);
  endtask

  task automatic program_block(bit [30:0] dt, bit [19:0] count, bit implicit_sel);
    wait_for_results();
    write_cfg(REG_TIME_STEP, dt);
    write_cfg(REG_STEP_COUNT, {11'd0, count});
    write_cfg(REG_SCHEME, {30'd0, implicit_sel});
    cfg_wen <= 1'b0;
  endtask

  function automatic bit [30:0] pick_start();
    case ($urandom_range(9))
      0: return '0;
      1: return UNITY31;
      2: return 31'($urandom);
      3: return 31'($urandom_range(255));
      default: return 31'($urandom_range(32'h4000_0000));
    endcase
  endfunction

  function automatic bit [30:0] pick_step();
    case ($urandom_range(7))
      0: return '0;
      1: return UNITY31;
      2: return 31'($urandom);
      3: return 31'($urandom_range(1024, 1));
      default: return 31'($urandom_range(32'h4000_0000, 1));
    endcase
  endfunction

  initial begin
    int phase;
    int blk;
    int k;
    board = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: dt 1.0, one explicit step
    send('0);
    send(UNITY31);
    send(31'h2000_0000);
    send(31'h7fff_ffff);
    send(UNITY31 + 31'd1);
    program_block('0, 20'd3, 1'b0);
    send(31'h1000_0000);
    send(UNITY31);
    program_block(31'h7fff_ffff, 20'd2, 1'b0);
    send(31'h1555_5555);
    send(31'd1);
    program_block(UNITY31, 20'd0, 1'b0);
    send(31'h7fff_ffff);
    send(31'h0003_0039);
    program_block(UNITY31, 20'd2, 1'b1);
    send('0);
    send(UNITY31);
    send(31'h2000_0000);
    program_block('0, 20'd1, 1'b1);
    send(31'h2000_0000);
    send(UNITY31);
    program_block(31'd1, 20'd4, 1'b1);
    send(UNITY31);
    send(31'd7);
    program_block(31'h2000_0000, 20'd3, 1'b1);
    send(31'h7fff_ffff);
    send(31'd1);
    program_block(31'h0010_0000, 20'd3000, 1'b0);
    send(31'h0000_4000);

    for (phase = 0; phase < 3; phase++) begin
      tx_idle_pct  = phase == 0 ? 19 : phase == 1 ? 75 : 0;
      rx_stall_pct = phase == 0 ? 75 : phase == 1 ? 19 : 0;
      for (blk = 0; blk < 4; blk++) begin
        program_block(pick_step(), 20'($urandom_range(8)), 1'($urandom_range(1)));
        for (k = 0; k < 8; k++) begin
          if ($urandom_range(15) == 0) wait_for_results();
          send(pick_start());
        end
      end
    end

    wait_for_results();
    repeat (200) @(posedge clk);
    if (board.pending() != 0) board.report("missing final_value", '0, board.expected_finals[0]);
    $display("covered %0d requests and %0d final values, explicit and implicit schemes,",
             board.requests, board.finals_checked);
    $display("step counts 0 to 3000, step sizes from zero to above one, stalls on both sides");
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
